FILE: rtl/core/contention_window_pi_controller_assert.svh
// assertion macros for the contention window pi controller
`ifndef CONTENTION_WINDOW_PI_CONTROLLER_ASSERT_SVH
`define CONTENTION_WINDOW_PI_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CWPI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cwpi assertion failed");
// next-cycle implication
`define CWPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cwpi assertion failed");
`else
`define CWPI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CWPI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/cwpi_pkg.sv
package cwpi_pkg;

    localparam int COUNT_BITS  = 24;
    localparam int FRAC_BITS   = 16;
    localparam int GAIN_BITS   = 16;
    localparam int DEV_BITS    = 8;
    localparam int NIBBLE_BITS = 4;
    localparam int CODE_BITS   = 2 * NIBBLE_BITS;
    localparam int SETP_BITS   = FRAC_BITS + 1;
    localparam int TOTAL_BITS  = COUNT_BITS + 2;
    localparam int QUO_BITS    = FRAC_BITS + 1;
    localparam int DIV_STEPS   = QUO_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);
    localparam int ERR_BITS    = SETP_BITS + 1;
    localparam int INTEG_BITS  = 32;

    // integer part of the scaled control word starts here
    localparam int WHOLE_SHIFT = FRAC_BITS + GAIN_BITS;
    // control values at or above 16 << WHOLE_SHIFT give the full code for any nonzero device count
    localparam int CAP_BITS    = WHOLE_SHIFT + NIBBLE_BITS + 1;
    localparam int MUL_A_BITS  = CAP_BITS + 1;
    localparam int MUL_B_BITS  = GAIN_BITS + 1;
    localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
    localparam int WHOLE_BITS  = PROD_BITS - WHOLE_SHIFT;

    localparam logic [CAP_BITS-1:0] CAP_LIMIT = {1'b1, {(CAP_BITS-1){1'b0}}};
    localparam logic [NIBBLE_BITS-1:0] NIBBLE_MAX = '1;
    localparam logic [CODE_BITS-1:0]   CODE_FULL  = '1;
    localparam logic [CODE_BITS-1:0]   CODE_NONE  = '0;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = SETP_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEVICES_ONE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEVICES_TWO = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SETPOINT    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PROP_GAIN   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INTEG_GAIN  = 3'd4;

    localparam logic [DEV_BITS-1:0]  RST_DEVICES    = 8'd1;
    localparam logic [SETP_BITS-1:0] RST_SETPOINT   = 17'd60293;
    localparam logic [GAIN_BITS-1:0] RST_PROP_GAIN  = 16'd15552;
    localparam logic [GAIN_BITS-1:0] RST_INTEG_GAIN = 16'd26444;

    // integer part of a non-negative scaled product coded as a window byte
    function automatic logic [CODE_BITS-1:0] window_code(input logic [PROD_BITS-1:0] prod);
        logic [WHOLE_BITS-1:0] whole;
        whole = prod[PROD_BITS-1:WHOLE_SHIFT];
        if (whole > WHOLE_BITS'(NIBBLE_MAX)) begin
            return CODE_FULL;
        end
        return {whole[NIBBLE_BITS-1:0], whole[NIBBLE_BITS-1:0]};
    endfunction

endpackage

FILE: rtl/core/contention_window_pi_controller.sv
// contention window pi controller
// one request on the s_axis channel carries a control period's counts of idle slots
// and of frames from two sharing groups; one result leaves on m_axis for each request.
// the idle fraction idle / total (16 fraction bits) is found by a serial divider,
// subtracted from the setpoint, and the error feeds one saturating 32-bit integrator.
// one shared multiplier forms kp * error + ki * integral and then scales that control
// word by each group's device count; the integer part becomes a window byte
// (0x00 below zero, 0xff above 15, else the nibble repeated).
// the divider holds the sequencer in S_DIV while it works out the 17 quotient bits and
// raises done, then eight steps follow, four of them through the shared multiplier.
// a new request is taken only once the last result has left S_OUT; s_axis_tready is
// high only while idle.
// a finished result waits in the output register while m_axis_tready is low; the
// next request is taken meanwhile and its result is held back until the register frees.
// configuration writes on the cfg channel are always ready and must only come while idle.
// reset (synchronous, active low) loads the default registers and clears the integrator.
module contention_window_pi_controller (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // idle_slot_count [23:0], group_one_frames [47:24], group_two_frames [71:48]
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [3*cwpi_pkg::COUNT_BITS-1:0]       s_axis_tdata,
    // window_code_one [7:0], window_code_two [15:8]
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [2*cwpi_pkg::CODE_BITS-1:0]        m_axis_tdata,
    // zero_total [0]
    output logic                                    m_axis_tuser,
    // configuration writes
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [cwpi_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [cwpi_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DIV   = 10'b00_0000_0010,
        S_INTEG = 10'b00_0000_0100,
        S_MUL_I = 10'b00_0000_1000,
        S_MUL_P = 10'b00_0001_0000,
        S_ADD   = 10'b00_0010_0000,
        S_CAP   = 10'b00_0100_0000,
        S_MUL_1 = 10'b00_1000_0000,
        S_MUL_2 = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    // control registers
    t_state                                  r_state;
    t_state                                  n_state;
    logic                                    r_out_valid;
    logic signed [cwpi_pkg::INTEG_BITS-1:0]  r_integ;

    // configuration
    logic [cwpi_pkg::DEV_BITS-1:0]           r_dev_one;
    logic [cwpi_pkg::DEV_BITS-1:0]           r_dev_two;
    logic [cwpi_pkg::SETP_BITS-1:0]          r_setp;
    logic [cwpi_pkg::GAIN_BITS-1:0]          r_kp;
    logic [cwpi_pkg::GAIN_BITS-1:0]          r_ki;

    // datapath
    logic                                    r_zero;
    logic signed [cwpi_pkg::ERR_BITS-1:0]    r_err;
    logic signed [cwpi_pkg::PROD_BITS-1:0]   r_acc;
    logic [cwpi_pkg::CAP_BITS-1:0]           r_cap;
    logic [cwpi_pkg::CODE_BITS-1:0]          r_code_one;
    logic [2*cwpi_pkg::CODE_BITS-1:0]        r_out_data;
    logic                                    r_out_zero;

    logic [cwpi_pkg::COUNT_BITS-1:0]         w_idle;
    logic [cwpi_pkg::COUNT_BITS-1:0]         w_frames_one;
    logic [cwpi_pkg::COUNT_BITS-1:0]         w_frames_two;
    logic [cwpi_pkg::TOTAL_BITS-1:0]         w_total;
    logic                                    w_accept;
    logic                                    w_out_free;
    logic                                    w_div_done;
    logic [cwpi_pkg::QUO_BITS-1:0]           w_quotient;
    logic [cwpi_pkg::QUO_BITS-1:0]           w_fraction;
    logic signed [cwpi_pkg::ERR_BITS-1:0]    w_err;
    logic signed [cwpi_pkg::INTEG_BITS:0]    w_integ_sum;
    logic signed [cwpi_pkg::INTEG_BITS-1:0]  w_integ_sat;
    logic [cwpi_pkg::CAP_BITS-1:0]           w_cap;
    logic                                    w_mul_en;
    logic signed [cwpi_pkg::MUL_A_BITS-1:0]  w_mul_a;
    logic signed [cwpi_pkg::MUL_B_BITS-1:0]  w_mul_b;
    logic signed [cwpi_pkg::PROD_BITS-1:0]   w_prod;

    // input fields, lowest first
    assign w_idle       = s_axis_tdata[cwpi_pkg::COUNT_BITS-1:0];
    assign w_frames_one = s_axis_tdata[2*cwpi_pkg::COUNT_BITS-1:cwpi_pkg::COUNT_BITS];
    assign w_frames_two = s_axis_tdata[3*cwpi_pkg::COUNT_BITS-1:2*cwpi_pkg::COUNT_BITS];
    assign w_total      = cwpi_pkg::TOTAL_BITS'(w_idle) + cwpi_pkg::TOTAL_BITS'(w_frames_one)
                        + cwpi_pkg::TOTAL_BITS'(w_frames_two);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    cwpi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (w_idle),
        .i_divisor  (w_total),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // error and saturating integrator update
    assign w_fraction  = r_zero ? '0 : w_quotient;
    assign w_err       = $signed({1'b0, r_setp}) - $signed({1'b0, w_fraction});
    assign w_integ_sum = $signed({r_integ[cwpi_pkg::INTEG_BITS-1], r_integ})
                       + $signed({{(cwpi_pkg::INTEG_BITS + 1 - cwpi_pkg::ERR_BITS)
                                    {w_err[cwpi_pkg::ERR_BITS-1]}}, w_err});

    always_comb begin
        w_integ_sat = w_integ_sum[cwpi_pkg::INTEG_BITS-1:0];
        if (w_integ_sum[cwpi_pkg::INTEG_BITS] != w_integ_sum[cwpi_pkg::INTEG_BITS-1]) begin
            // overflow: clamp to the end the true sum lies beyond
            w_integ_sat = w_integ_sum[cwpi_pkg::INTEG_BITS]
                        ? {1'b1, {(cwpi_pkg::INTEG_BITS-1){1'b0}}}
                        : {1'b0, {(cwpi_pkg::INTEG_BITS-1){1'b1}}};
        end
    end

    // negative control gives code 0 for any device count; large control saturates
    always_comb begin
        if (r_acc[cwpi_pkg::PROD_BITS-1]) begin
            w_cap = '0;
        end else if (|r_acc[cwpi_pkg::PROD_BITS-2:cwpi_pkg::CAP_BITS-1]) begin
            w_cap = cwpi_pkg::CAP_LIMIT;
        end else begin
            w_cap = r_acc[cwpi_pkg::CAP_BITS-1:0];
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        w_mul_en = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        case (r_state)
            S_MUL_I: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed({{(cwpi_pkg::MUL_A_BITS - cwpi_pkg::INTEG_BITS)
                                     {r_integ[cwpi_pkg::INTEG_BITS-1]}}, r_integ});
                w_mul_b  = $signed({1'b0, r_ki});
            end
            S_MUL_P: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed({{(cwpi_pkg::MUL_A_BITS - cwpi_pkg::ERR_BITS)
                                     {r_err[cwpi_pkg::ERR_BITS-1]}}, r_err});
                w_mul_b  = $signed({1'b0, r_kp});
            end
            S_MUL_1: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed({1'b0, r_cap});
                w_mul_b  = $signed({{(cwpi_pkg::MUL_B_BITS - cwpi_pkg::DEV_BITS){1'b0}},
                                    r_dev_one});
            end
            S_MUL_2: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed({1'b0, r_cap});
                w_mul_b  = $signed({{(cwpi_pkg::MUL_B_BITS - cwpi_pkg::DEV_BITS){1'b0}},
                                    r_dev_two});
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    cwpi_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_DIV;
            S_DIV:   if (w_div_done) n_state = S_INTEG;
            S_INTEG: n_state = S_MUL_I;
            S_MUL_I: n_state = S_MUL_P;
            S_MUL_P: n_state = S_ADD;
            S_ADD:   n_state = S_CAP;
            S_CAP:   n_state = S_MUL_1;
            S_MUL_1: n_state = S_MUL_2;
            S_MUL_2: n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_dev_one   <= cwpi_pkg::RST_DEVICES;
            r_dev_two   <= cwpi_pkg::RST_DEVICES;
            r_setp      <= cwpi_pkg::RST_SETPOINT;
            r_kp        <= cwpi_pkg::RST_PROP_GAIN;
            r_ki        <= cwpi_pkg::RST_INTEG_GAIN;
        end else begin
            r_state <= n_state;
            if (r_state == S_INTEG) begin
                r_integ <= w_integ_sat;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    cwpi_pkg::CFG_DEVICES_ONE: r_dev_one <= i_cfg_data[cwpi_pkg::DEV_BITS-1:0];
                    cwpi_pkg::CFG_DEVICES_TWO: r_dev_two <= i_cfg_data[cwpi_pkg::DEV_BITS-1:0];
                    cwpi_pkg::CFG_SETPOINT:    r_setp    <= i_cfg_data;
                    cwpi_pkg::CFG_PROP_GAIN:   r_kp      <= i_cfg_data[cwpi_pkg::GAIN_BITS-1:0];
                    cwpi_pkg::CFG_INTEG_GAIN:  r_ki      <= i_cfg_data[cwpi_pkg::GAIN_BITS-1:0];
                    default: begin
                        // unmapped index, write dropped
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_zero <= (w_total == '0);
        end
        if (r_state == S_INTEG) begin
            r_err <= w_err;
        end
        if (r_state == S_MUL_P) begin
            r_acc <= w_prod;
        end
        if (r_state == S_ADD) begin
            r_acc <= r_acc + w_prod;
        end
        if (r_state == S_CAP) begin
            r_cap <= w_cap;
        end
        if (r_state == S_MUL_2) begin
            r_code_one <= cwpi_pkg::window_code(w_prod);
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_data <= {cwpi_pkg::window_code(w_prod), r_code_one};
            r_out_zero <= r_zero;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_zero;
    assign o_cfg_ready   = 1'b1;

`include "contention_window_pi_controller_assert.svh"

    // a request always starts the divider pass
    `CWPI_ASSERT_NEXT(a_accept_to_div, i_clk, i_rst_n, w_accept, r_state == S_DIV)
    // the divider only finishes while the sequencer waits for it
    `CWPI_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, w_div_done, r_state == S_DIV)
    // a finished result reaches the output register once it is free
    `CWPI_ASSERT_NEXT(a_out_loaded, i_clk, i_rst_n, (r_state == S_OUT) && w_out_free,
        m_axis_tvalid)

endmodule

FILE: rtl/core/cwpi_div.sv
module cwpi_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [cwpi_pkg::COUNT_BITS-1:0] i_dividend,
    input  logic [cwpi_pkg::TOTAL_BITS-1:0] i_divisor,
    output logic                            o_done,
    output logic [cwpi_pkg::QUO_BITS-1:0]   o_quotient
);

    // restoring divider of (dividend << FRAC_BITS) / divisor, one quotient bit a cycle;
    // the quotient never exceeds 1.0 so only the low QUO_BITS bits are worked out
    logic                                r_busy;
    logic                                r_done;
    logic [cwpi_pkg::DIV_CNT_BITS-1:0]   r_cnt;
    logic [cwpi_pkg::TOTAL_BITS-1:0]     r_rem;
    logic [cwpi_pkg::TOTAL_BITS-1:0]     r_div;
    logic [cwpi_pkg::QUO_BITS-1:0]       r_quo;
    logic                                r_bit;

    logic [cwpi_pkg::TOTAL_BITS:0]       n_trial;
    logic                                n_ge;

    assign n_trial = {r_rem, r_bit};
    assign n_ge    = n_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == cwpi_pkg::DIV_CNT_BITS'(cwpi_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // top dividend bits sit below the divisor already
            r_rem <= cwpi_pkg::TOTAL_BITS'(i_dividend >> 1);
            r_bit <= i_dividend[0];
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_bit <= 1'b0;
            r_quo <= {r_quo[cwpi_pkg::QUO_BITS-2:0], n_ge};
            if (n_ge) begin
                r_rem <= cwpi_pkg::TOTAL_BITS'(n_trial - {1'b0, r_div});
            end else begin
                r_rem <= n_trial[cwpi_pkg::TOTAL_BITS-1:0];
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/core/cwpi_mul.sv
module cwpi_mul (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [cwpi_pkg::MUL_A_BITS-1:0] i_a,
    input  logic signed [cwpi_pkg::MUL_B_BITS-1:0] i_b,
    output logic signed [cwpi_pkg::PROD_BITS-1:0]  o_prod
);

    // shared signed multiplier, product registered and held until the next use
    logic signed [cwpi_pkg::PROD_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: bench/window_code_checker.sv
`timescale 1ns / 1ps

module window_code_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    input  logic                                    s_axis_tready,
    input  logic [3*cwpi_pkg::COUNT_BITS-1:0]       s_axis_tdata,
    input  logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    input  logic [2*cwpi_pkg::CODE_BITS-1:0]        m_axis_tdata,
    input  logic                                    m_axis_tuser,
    input  logic                                    i_cfg_valid,
    input  logic                                    o_cfg_ready,
    input  logic [cwpi_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [cwpi_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    output int                                      o_fail_count,
    output int                                      o_pending
);

    localparam longint INTEGRAL_TOP    = (longint'(1) <<< (cwpi_pkg::INTEG_BITS - 1)) - 1;
    localparam longint INTEGRAL_BOTTOM = -(longint'(1) <<< (cwpi_pkg::INTEG_BITS - 1));

    typedef struct packed {
        logic [cwpi_pkg::CODE_BITS-1:0] code_one;
        logic [cwpi_pkg::CODE_BITS-1:0] code_two;
        logic                           zero_total;
    } t_window_codes;

    t_window_codes expected_codes[$];

    logic [cwpi_pkg::DEV_BITS-1:0]  devices_one;
    logic [cwpi_pkg::DEV_BITS-1:0]  devices_two;
    logic [cwpi_pkg::SETP_BITS-1:0] setpoint;
    logic [cwpi_pkg::GAIN_BITS-1:0] prop_gain;
    logic [cwpi_pkg::GAIN_BITS-1:0] integ_gain;
    int                             error_integral;

    // integer part of control * devices as a window byte
    function automatic logic [cwpi_pkg::CODE_BITS-1:0] code_from_control(
            input longint control, input logic [cwpi_pkg::DEV_BITS-1:0] devices);
        longint scaled;
        longint whole;
        scaled = control * longint'(devices);
        if (scaled < 0) begin
            return cwpi_pkg::CODE_NONE;
        end
        whole = scaled >>> cwpi_pkg::WHOLE_SHIFT;
        if (whole > longint'(cwpi_pkg::NIBBLE_MAX)) begin
            return cwpi_pkg::CODE_FULL;
        end
        return {whole[cwpi_pkg::NIBBLE_BITS-1:0], whole[cwpi_pkg::NIBBLE_BITS-1:0]};
    endfunction

    always @(posedge i_clk) begin : track
        longint        idle;
        longint        total;
        longint        fraction;
        longint        error;
        longint        sum;
        longint        control;
        t_window_codes want;
        t_window_codes got;
        if (!i_rst_n) begin
            devices_one    = cwpi_pkg::RST_DEVICES;
            devices_two    = cwpi_pkg::RST_DEVICES;
            setpoint       = cwpi_pkg::RST_SETPOINT;
            prop_gain      = cwpi_pkg::RST_PROP_GAIN;
            integ_gain     = cwpi_pkg::RST_INTEG_GAIN;
            error_integral = 0;
            expected_codes.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    cwpi_pkg::CFG_DEVICES_ONE:
                        devices_one = i_cfg_data[cwpi_pkg::DEV_BITS-1:0];
                    cwpi_pkg::CFG_DEVICES_TWO:
                        devices_two = i_cfg_data[cwpi_pkg::DEV_BITS-1:0];
                    cwpi_pkg::CFG_SETPOINT:
                        setpoint    = i_cfg_data[cwpi_pkg::SETP_BITS-1:0];
                    cwpi_pkg::CFG_PROP_GAIN:
                        prop_gain   = i_cfg_data[cwpi_pkg::GAIN_BITS-1:0];
                    cwpi_pkg::CFG_INTEG_GAIN:
                        integ_gain  = i_cfg_data[cwpi_pkg::GAIN_BITS-1:0];
                    default: ;
                endcase
            end
            // results leave before a new request can be retired, so pop first
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[cwpi_pkg::CODE_BITS-1:0],
                       m_axis_tdata[2*cwpi_pkg::CODE_BITS-1:cwpi_pkg::CODE_BITS],
                       m_axis_tuser};
                if (expected_codes.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result, expected none, actual codes %h %h zero %b",
                             $time, got.code_one, got.code_two, got.zero_total);
                end else begin
                    want = expected_codes.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        $display("%0t: mismatch, expected codes %h %h zero %b, %s %h %h zero %b",
                                 $time, want.code_one, want.code_two, want.zero_total,
                                 "actual", got.code_one, got.code_two, got.zero_total);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                idle  = longint'(s_axis_tdata[cwpi_pkg::COUNT_BITS-1:0]);
                total = idle
                      + longint'(s_axis_tdata[2*cwpi_pkg::COUNT_BITS-1:cwpi_pkg::COUNT_BITS])
                      + longint'(s_axis_tdata[3*cwpi_pkg::COUNT_BITS-1:2*cwpi_pkg::COUNT_BITS]);
                fraction = (total == 0) ? 0 : (idle <<< cwpi_pkg::FRAC_BITS) / total;
                error = longint'(setpoint) - fraction;
                sum   = longint'(error_integral) + error;
                if (sum > INTEGRAL_TOP) sum = INTEGRAL_TOP;
                if (sum < INTEGRAL_BOTTOM) sum = INTEGRAL_BOTTOM;
                error_integral = int'(sum);
                control = longint'(prop_gain) * error + longint'(integ_gain) * sum;
                want.code_one   = code_from_control(control, devices_one);
                want.code_two   = code_from_control(control, devices_two);
                want.zero_total = (total == 0);
                expected_codes.push_back(want);
            end
        end
        o_pending <= expected_codes.size();
    end

endmodule

FILE: bench/tb_contention_window_pi_controller.sv
`timescale 1ns / 1ps

module tb_contention_window_pi_controller;

    localparam int HOLD_OFF_CYCLES  = 300;
    // margin after the last result
    localparam int DRAIN_CYCLES     = 40;
    localparam int PHASE_ITEMS      = 200;
    // a run of the largest error with a unit integral gain, so that the
    // growing integral shows up in the codes
    localparam int CLIMB_ITEMS      = 200;
    localparam int RUN_LIMIT_NS     = 10_000_000;
    localparam logic [cwpi_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [cwpi_pkg::SETP_BITS-1:0]  SETP_MAX  = '1;
    localparam logic [cwpi_pkg::GAIN_BITS-1:0]  GAIN_MAX  = '1;
    localparam logic [cwpi_pkg::DEV_BITS-1:0]   DEV_MAX   = '1;
    localparam logic [cwpi_pkg::SETP_BITS-1:0]  SETP_ONE  =
        cwpi_pkg::SETP_BITS'(1) << cwpi_pkg::FRAC_BITS;

    logic                                   i_clk         = 1'b0;
    logic                                   i_rst_n       = 1'b0;
    logic                                   s_axis_tvalid = 1'b0;
    logic                                   s_axis_tready;
    // idle_slot_count [23:0], group_one_frames [47:24], group_two_frames [71:48]
    logic [3*cwpi_pkg::COUNT_BITS-1:0]      s_axis_tdata  = '0;
    logic                                   m_axis_tvalid;
    logic                                   m_axis_tready = 1'b0;
    // window_code_one [7:0], window_code_two [15:8]
    logic [2*cwpi_pkg::CODE_BITS-1:0]       m_axis_tdata;
    // zero_total [0]
    logic                                   m_axis_tuser;
    logic                                   i_cfg_valid   = 1'b0;
    logic                                   o_cfg_ready;
    logic [cwpi_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index   = '0;
    logic [cwpi_pkg::CFG_DATA_BITS-1:0]     i_cfg_data    = '0;

    int                                     fail_count;
    int                                     pending;

    // pacing controls: gaps_on is shared by the sender and the receiver, hold_off_pending drives the receiver
    bit                                     gaps_on          = 1'b1;
    bit                                     hold_off_pending = 1'b0;
    // setpoint in force, so that random periods can be aimed near it
    logic [cwpi_pkg::SETP_BITS-1:0]         current_setpoint = cwpi_pkg::RST_SETPOINT;

    contention_window_pi_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    window_code_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // gap before a request: mostly none, some short, a few long
    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (!gaps_on || pick < 60) begin
            return 0;
        end
        if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // count of random magnitude so that small and large totals both show up
    function automatic logic [cwpi_pkg::COUNT_BITS-1:0] random_count();
        int width;
        width = $urandom_range(1, cwpi_pkg::COUNT_BITS);
        return cwpi_pkg::COUNT_BITS'($urandom) >> (cwpi_pkg::COUNT_BITS - width);
    endfunction

    function automatic logic [cwpi_pkg::COUNT_BITS-1:0] extreme_count();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return COUNT_MAX;
            2: return cwpi_pkg::COUNT_BITS'(1);
            default: return cwpi_pkg::COUNT_BITS'($urandom);
        endcase
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                if ($urandom_range(0, 99) < 85) begin
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    repeat ($urandom_range(10, 50)) @(posedge i_clk);
                end
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // one request on s_axis; tvalid stays high afterwards so back-to-back
    // requests need no extra edge, the next gap or the drain lowers it
    task automatic send_counts(input logic [cwpi_pkg::COUNT_BITS-1:0] idle,
                               input logic [cwpi_pkg::COUNT_BITS-1:0] frames_one,
                               input logic [cwpi_pkg::COUNT_BITS-1:0] frames_two);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {frames_two, frames_one, idle};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_random_period();
        int                              kind;
        longint                          frames;
        longint                          idle;
        longint                          noise;
        logic [cwpi_pkg::COUNT_BITS-1:0] idle_count;
        logic [cwpi_pkg::COUNT_BITS-1:0] frames_one;
        logic [cwpi_pkg::COUNT_BITS-1:0] frames_two;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            // idle fraction close to the setpoint keeps the integrator wandering
            frames     = longint'($urandom_range(1, 1 << $urandom_range(1, 22)));
            frames_one = cwpi_pkg::COUNT_BITS'($urandom_range(0, int'(frames)));
            frames_two = cwpi_pkg::COUNT_BITS'(frames - longint'(frames_one));
            if (current_setpoint >= SETP_ONE) begin
                idle_count = random_count();
                frames_one = '0;
                frames_two = cwpi_pkg::COUNT_BITS'($urandom_range(0, 1));
            end else begin
                idle = frames * longint'(current_setpoint)
                     / (longint'(SETP_ONE) - longint'(current_setpoint));
                if (idle > longint'(COUNT_MAX)) idle = longint'(COUNT_MAX);
                noise = idle / 16 + 1;
                idle  = idle + longint'($urandom_range(0, int'(2 * noise))) - noise;
                if (idle < 0) idle = 0;
                if (idle > longint'(COUNT_MAX)) idle = longint'(COUNT_MAX);
                idle_count = cwpi_pkg::COUNT_BITS'(idle);
            end
        end else if (kind < 75) begin
            idle_count = random_count();
            frames_one = random_count();
            frames_two = random_count();
        end else if (kind < 85) begin
            idle_count = extreme_count();
            frames_one = extreme_count();
            frames_two = extreme_count();
        end else if (kind < 90) begin
            // zero total
            idle_count = '0;
            frames_one = '0;
            frames_two = '0;
        end else begin
            // at most one of the three counts is nonzero
            idle_count = '0;
            frames_one = '0;
            frames_two = '0;
            case ($urandom_range(0, 2))
                0: idle_count = random_count();
                1: frames_one = random_count();
                default: frames_two = random_count();
            endcase
        end
        send_counts(idle_count, frames_one, frames_two);
    endtask

    // one register write; cfg valid stays high for the next write
    task automatic put_register(input logic [cwpi_pkg::CFG_INDEX_BITS-1:0] index,
                                input logic [cwpi_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // all five registers, unused upper data bits filled with noise
    task automatic write_settings(input logic [cwpi_pkg::DEV_BITS-1:0] devices_one,
                                  input logic [cwpi_pkg::DEV_BITS-1:0] devices_two,
                                  input logic [cwpi_pkg::SETP_BITS-1:0] setpoint,
                                  input logic [cwpi_pkg::GAIN_BITS-1:0] prop_gain,
                                  input logic [cwpi_pkg::GAIN_BITS-1:0] integ_gain,
                                  input bit stray_write);
        put_register(cwpi_pkg::CFG_DEVICES_ONE,
                     {(cwpi_pkg::CFG_DATA_BITS-cwpi_pkg::DEV_BITS)'($urandom), devices_one});
        put_register(cwpi_pkg::CFG_DEVICES_TWO,
                     {(cwpi_pkg::CFG_DATA_BITS-cwpi_pkg::DEV_BITS)'($urandom), devices_two});
        put_register(cwpi_pkg::CFG_SETPOINT, setpoint);
        put_register(cwpi_pkg::CFG_PROP_GAIN,
                     {(cwpi_pkg::CFG_DATA_BITS-cwpi_pkg::GAIN_BITS)'($urandom), prop_gain});
        put_register(cwpi_pkg::CFG_INTEG_GAIN,
                     {(cwpi_pkg::CFG_DATA_BITS-cwpi_pkg::GAIN_BITS)'($urandom), integ_gain});
        if (stray_write) begin
            // an index past the last register must change nothing
            put_register(cwpi_pkg::CFG_INTEG_GAIN
                         + cwpi_pkg::CFG_INDEX_BITS'($urandom_range(1, 3)),
                         cwpi_pkg::CFG_DATA_BITS'($urandom));
        end
        i_cfg_valid <= 1'b0;
        current_setpoint = setpoint;
    endtask

    // wait until every result is back and the block has gone quiet
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [cwpi_pkg::DEV_BITS-1:0]  devices_one;
        logic [cwpi_pkg::DEV_BITS-1:0]  devices_two;
        logic [cwpi_pkg::SETP_BITS-1:0] setpoint;
        logic [cwpi_pkg::GAIN_BITS-1:0] prop_gain;
        logic [cwpi_pkg::GAIN_BITS-1:0] integ_gain;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed periods on the reset settings
        send_counts('0, '0, '0);                   // zero total
        send_counts(COUNT_MAX, '0, '0);            // fraction of exactly one
        send_counts('0, COUNT_MAX, COUNT_MAX);     // fraction zero, largest frames
        send_counts(COUNT_MAX, COUNT_MAX, COUNT_MAX);
        send_counts(cwpi_pkg::COUNT_BITS'(1), COUNT_MAX, '0);
        send_counts('0, '0, cwpi_pkg::COUNT_BITS'(1));
        // busy medium: integral and codes climb step by step
        repeat (8) send_counts('0, random_count(), random_count());
        send_counts('0, '0, '0);
        // fully idle medium pulls the control back toward zero
        repeat (3) send_counts(COUNT_MAX, '0, '0);
        send_counts(cwpi_pkg::COUNT_BITS'(1), '0, '0);
        send_counts(cwpi_pkg::COUNT_BITS'(1), '0, COUNT_MAX);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_settings(8'd2, 8'd5, cwpi_pkg::RST_SETPOINT, cwpi_pkg::RST_PROP_GAIN,
                                  cwpi_pkg::RST_INTEG_GAIN, 1'b0);
                // zero devices on one side, largest scale on the other
                1: write_settings('0, DEV_MAX, SETP_ONE, GAIN_MAX, GAIN_MAX, 1'b0);
                2: write_settings(DEV_MAX, '0, '0, GAIN_MAX, '0, 1'b0);
                // setpoint above one, small gains
                3: write_settings(8'd4, 8'd9, SETP_MAX, 16'd300, 16'd20, 1'b0);
                default: begin
                    devices_one = ($urandom_range(0, 7) == 0)
                                ? cwpi_pkg::DEV_BITS'($urandom)
                                : cwpi_pkg::DEV_BITS'($urandom_range(0, 31));
                    devices_two = ($urandom_range(0, 7) == 0)
                                ? cwpi_pkg::DEV_BITS'($urandom)
                                : cwpi_pkg::DEV_BITS'($urandom_range(0, 31));
                    setpoint    = cwpi_pkg::SETP_BITS'($urandom_range(0, int'(SETP_MAX)));
                    prop_gain   = cwpi_pkg::GAIN_BITS'($urandom)
                                >> $urandom_range(0, cwpi_pkg::GAIN_BITS - 1);
                    integ_gain  = cwpi_pkg::GAIN_BITS'($urandom)
                                >> $urandom_range(0, cwpi_pkg::GAIN_BITS - 1);
                    write_settings(devices_one, devices_two, setpoint, prop_gain, integ_gain,
                                   phase == 6);
                end
            endcase
            // one phase runs flat out with no idling on either side
            gaps_on = (phase != 3);
            for (int item = 0; item < PHASE_ITEMS; item++) begin
                // long receiver hold-off while the sender keeps offering
                if (phase == 5 && item == 40) begin
                    hold_off_pending = 1'b1;
                end
                send_random_period();
            end
            drain();
        end

        // largest error in the climb periods, only the integral term in the control
        gaps_on = 1'b0;
        write_settings(DEV_MAX, 8'd128, SETP_MAX, '0, cwpi_pkg::GAIN_BITS'(1), 1'b0);
        repeat (CLIMB_ITEMS) send_counts('0, cwpi_pkg::COUNT_BITS'(1), '0);
        repeat (5) send_counts(random_count(), '0, '0);
        drain();
        // step back down
        gaps_on = 1'b1;
        write_settings(8'd16, 8'd32, '0, '0, cwpi_pkg::GAIN_BITS'(1), 1'b0);
        repeat (10) send_counts(COUNT_MAX, '0, '0);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("tb_contention_window_pi_controller OK");
        end else begin
            $display("tb_contention_window_pi_controller NOT OK");
        end
        $finish;
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb_contention_window_pi_controller NOT OK");
        $finish;
    end

endmodule
